// ===== src/tether_winch_step_planner_macros.svh =====
// Assertion macros for the tether winch step planner.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef TETHER_WINCH_STEP_PLANNER_MACROS_SVH
`define TETHER_WINCH_STEP_PLANNER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define TWSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define TWSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TWSP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TWSP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/twsp_pkg.sv =====
// Shared types and constants for the tether winch step planner.
// No dependencies; imported by twsp_isqrt, tether_winch_step_planner and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package twsp_pkg;

    // coordinate width (signed millimetres)
    localparam int COORD_BITS = 21;

    // magnitude of a coordinate difference needs one more bit
    localparam int OP_W   = COORD_BITS + 1;
    localparam int PROD_W = 2 * OP_W;
    // sum of three squares
    localparam int SQ_W   = PROD_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int ITER_W = $clog2(ROOT_W + 1);

    localparam int LENGTH_W = 22;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};

    localparam int SLACK_W = 16;
    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd300;

    // square/accumulate sequence: 6 issues, then the pipeline drains
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] TERMS   = 3'd3;
    localparam logic [CNT_W-1:0] ISSUES  = 3'd6;
    localparam logic [CNT_W-1:0] ACC_NEW = 3'd5;
    localparam logic [CNT_W-1:0] SQ_LAST = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic CMD_TAKEOFF  = 1'b0;
    localparam logic CMD_POSITION = 1'b1;

    localparam logic DIR_PAY_OUT = 1'b0;
    localparam logic DIR_REEL_IN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_EMIT
    } twsp_state_t;

endpackage

`default_nettype wire

// ===== src/twsp_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle (truncated result).
// Depends on twsp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module twsp_isqrt
    import twsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   busy,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [ITER_W-1:0] cnt_reg;
    logic              done_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // bring down the next two radicand bits, try appending a one
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ITER_W'(1));
            if (start)
                cnt_reg <= ITER_W'(ROOT_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - ITER_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== src/tether_winch_step_planner.sv =====
// Tether winch step planner top level: sequencer, shared multiplier, output register.
// Depends on twsp_pkg, twsp_isqrt and tether_winch_step_planner_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): command plus a signed x/y/z position in mm.
//   A transfer happens on a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid/out_stall): direction and length_mm of one winch move.
//   Config channel (cfg_valid/cfg_ready/cfg_data): slack length, always ready;
//   write it only while the block is idle.
//   Before takeoff, position reports are dropped; a dropped item leaves the block idle.
//   The first takeoff yields one pay-out move of the slack length: it passes through
//   ST_EMIT into the output register, where out_valid rises. Later takeoffs are dropped.
//   After takeoff, a position report keeps in_stall high while it passes through
//   the single shared 22x22 multiplier (six squares, pipelined, into two
//   accumulators), a compare, the 23 steps of the bit-serial square-root unit and
//   its done flag, and the load of the output register. out_valid rises as in_stall
//   drops, so the block takes no new report until the last one is through; the
//   root unit takes most of that time.
//   A result waiting on out_stall holds in the output register; the block accepts
//   the next item once that register has taken the result.
//   Reset: slack = 300 mm, last position = origin, not airborne, output empty.
`timescale 1ns / 1ps
`default_nettype none
`include "tether_winch_step_planner_macros.svh"

module tether_winch_step_planner
    import twsp_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic signed [COORD_BITS-1:0] pos_x_mm,
    input  wire logic signed [COORD_BITS-1:0] pos_y_mm,
    input  wire logic signed [COORD_BITS-1:0] pos_z_mm,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              direction,
    output logic [LENGTH_W-1:0]               length_mm,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [SLACK_W-1:0]           cfg_data
);

    // magnitude of a signed operand
    function automatic logic [OP_W-1:0] mag(input logic signed [OP_W-1:0] v);
        mag = v[OP_W-1] ? (~v + OP_W'(1)) : v;
    endfunction

    twsp_state_t state_reg, state_next;

    logic [CNT_W-1:0]              cnt_reg;
    logic                          airborne_reg;
    logic [SLACK_W-1:0]            slack_reg;

    logic signed [COORD_BITS-1:0]  cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [COORD_BITS-1:0]  last_x_reg, last_y_reg, last_z_reg;
    logic [SQ_W-1:0]               last_sq_reg;
    logic [SQ_W-1:0]               new_acc_reg;
    logic [SQ_W-1:0]               step_acc_reg;
    logic [OP_W-1:0]               op_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          dir_reg;
    logic [LENGTH_W-1:0]           len_hold_reg;

    logic                          out_valid_reg;
    logic                          out_dir_reg;
    logic [LENGTH_W-1:0]           out_len_reg;

    // control strobes from the FSM, the root unit and the handshakes
    logic in_accept;
    logic take_off;
    logic start_pos;
    logic root_start;
    logic root_busy;
    logic root_done;
    logic emit_load;
    logic out_free;

    logic [ROOT_W-1:0]   root_val;
    logic [1:0]          axis;
    logic signed [COORD_BITS-1:0] sel_cur, sel_last;
    logic signed [OP_W-1:0]       sel_diff;
    logic [OP_W-1:0]     op_c;
    logic [PROD_W-1:0]   prod_c;
    logic [LENGTH_W-1:0] root_sat;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // FSM state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // FSM next state and strobes
    always_comb
    begin
        state_next = state_reg;
        take_off   = 1'b0;
        start_pos  = 1'b0;
        root_start = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!airborne_reg && command == CMD_TAKEOFF)
                    begin
                        take_off   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (airborne_reg && command == CMD_POSITION)
                    begin
                        start_pos  = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (cnt_reg == SQ_LAST)
                    state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            airborne_reg  <= 1'b0;
            slack_reg     <= SLACK_RESET;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            last_sq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                slack_reg <= cfg_data;
            if (take_off)
                airborne_reg <= 1'b1;

            if (start_pos)
                cnt_reg <= '0;
            else if (state_reg == ST_SQUARE)
                cnt_reg <= cnt_reg + CNT_W'(1);

            // new position becomes the reference once its squares are done
            if (root_start)
            begin
                last_x_reg  <= cur_x_reg;
                last_y_reg  <= cur_y_reg;
                last_z_reg  <= cur_z_reg;
                last_sq_reg <= new_acc_reg;
            end

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // operand select: terms 0..2 are the new coordinates, 3..5 the step
    always_comb
    begin
        axis = (cnt_reg < TERMS) ? cnt_reg[1:0] : 2'(cnt_reg - TERMS);
        if (axis == AXIS_X)
        begin
            sel_cur  = cur_x_reg;
            sel_last = last_x_reg;
        end
        else if (axis == AXIS_Y)
        begin
            sel_cur  = cur_y_reg;
            sel_last = last_y_reg;
        end
        else
        begin
            sel_cur  = cur_z_reg;
            sel_last = last_z_reg;
        end
        sel_diff = OP_W'(sel_cur) - OP_W'(sel_last);
        op_c     = (cnt_reg < TERMS) ? mag(OP_W'(sel_cur)) : mag(sel_diff);
    end

    // the one shared multiplier
    assign prod_c = op_reg * op_reg;

    // truncate to the length field, saturating
    assign root_sat = ((ROOT_W + LENGTH_W)'(root_val) > (ROOT_W + LENGTH_W)'(LENGTH_MAX))
                      ? LENGTH_MAX : LENGTH_W'(root_val);

    // datapath
    always_ff @(posedge clk)
    begin
        if (start_pos)
        begin
            cur_x_reg    <= pos_x_mm;
            cur_y_reg    <= pos_y_mm;
            cur_z_reg    <= pos_z_mm;
            new_acc_reg  <= '0;
            step_acc_reg <= '0;
        end
        else if (state_reg == ST_SQUARE)
        begin
            if (cnt_reg < ISSUES)
                op_reg <= op_c;
            if (cnt_reg != '0 && cnt_reg <= ISSUES)
                prod_reg <= prod_c;
            // product of term cnt-2 lands here
            if (cnt_reg >= CNT_W'(2))
            begin
                if (cnt_reg < ACC_NEW)
                    new_acc_reg <= new_acc_reg + SQ_W'(prod_reg);
                else
                    step_acc_reg <= step_acc_reg + SQ_W'(prod_reg);
            end
        end

        if (take_off)
        begin
            dir_reg      <= DIR_PAY_OUT;
            len_hold_reg <= LENGTH_W'(slack_reg);
        end
        else if (root_start)
            dir_reg <= (new_acc_reg > last_sq_reg) ? DIR_PAY_OUT : DIR_REEL_IN;
        else if (state_reg == ST_ROOT_WAIT && root_done)
            len_hold_reg <= root_sat;

        if (emit_load)
        begin
            out_dir_reg <= dir_reg;
            out_len_reg <= len_hold_reg;
        end
    end

    twsp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (step_acc_reg),
        .busy     (root_busy),
        .done     (root_done),
        .root     (root_val)
    );

    assign out_valid = out_valid_reg;
    assign direction = out_dir_reg;
    assign length_mm = out_len_reg;

    // checks
    `TWSP_ASSERT_NXT(a_airborne_sticks, clk, rst_n, airborne_reg, airborne_reg)
    `TWSP_ASSERT_IMP(a_root_running, clk, rst_n, state_reg == ST_ROOT_WAIT, root_busy || root_done)
    `TWSP_ASSERT_NXT(a_takeoff_emits, clk, rst_n, take_off, state_reg == ST_EMIT && airborne_reg)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tether_winch_step_planner: directed table, then random phases.
// Depends on twsp_pkg and the planner RTL; predicts each winch move in-line and checks it.

module tb_top;
    import twsp_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;   // one full position report through the block
    localparam int TAIL_CYCLES   = 80;
    localparam int HOLD_AFTER    = 120;  // results checked before the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 5;
    localparam int REPORTS_PER_PHASE = 266;

    typedef enum logic [1:0] {
        CHK_SILENT,     // typed: no move may come out
        CHK_TYPED,      // typed move in the table row
        CHK_PREDICTED   // move (if any) from the predictor
    } row_check_t;

    typedef struct {
        logic       cmd;
        int         x;
        int         y;
        int         z;
        row_check_t chk;
        logic       dir;
        int         len;
    } probe_row_t;

    typedef struct packed {
        logic                dir;
        logic [LENGTH_W-1:0] len;
    } winch_move_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         command = CMD_TAKEOFF;
    logic signed [COORD_BITS-1:0] pos_x_mm = '0;
    logic signed [COORD_BITS-1:0] pos_y_mm = '0;
    logic signed [COORD_BITS-1:0] pos_z_mm = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                direction;
    logic [LENGTH_W-1:0] length_mm;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SLACK_W-1:0] cfg_data = '0;

    // predictor state
    logic [SLACK_W-1:0]           slack_mm = SLACK_RESET;
    logic signed [COORD_BITS-1:0] tether_last_x = '0;
    logic signed [COORD_BITS-1:0] tether_last_y = '0;
    logic signed [COORD_BITS-1:0] tether_last_z = '0;
    logic                         is_airborne = 1'b0;

    winch_move_t pending_moves[$];
    int error_count   = 0;
    int moves_checked = 0;
    int cycle_count   = 0;
    int sender_gap_pct = 0;   // chance of an input gap before each item
    int receiver_stall_pct = 0; // chance per cycle that the receiver starts a stall burst
    bit long_hold_done = 1'b0;

    // Directed probes: pre-takeoff drops, takeoff, repeated takeoff, extremes, equal norms.
    probe_row_t probe_rows [20] = '{
        '{CMD_POSITION, 5, 5, 5, CHK_SILENT, DIR_PAY_OUT, 0},
        '{CMD_POSITION, -1048576, 1048575, -1, CHK_SILENT, DIR_PAY_OUT, 0},
        '{CMD_TAKEOFF, 777, -777, 1048575, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_TAKEOFF, 0, 0, 0, CHK_SILENT, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 1000, 0, 0, CHK_TYPED, DIR_PAY_OUT, 1000},
        '{CMD_POSITION, 1000, 0, 0, CHK_TYPED, DIR_REEL_IN, 0},
        '{CMD_POSITION, 0, 0, 0, CHK_TYPED, DIR_REEL_IN, 1000},
        '{CMD_POSITION, 0, 0, 0, CHK_TYPED, DIR_REEL_IN, 0},
        '{CMD_POSITION, 0, 3, 4, CHK_TYPED, DIR_PAY_OUT, 5},
        '{CMD_POSITION, -1048576, -1048576, -1048576, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 1048575, 1048575, 1048575, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 1048575, 1048575, 1048575, CHK_TYPED, DIR_REEL_IN, 0},
        '{CMD_POSITION, -1048576, 0, 0, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 1048575, 0, 0, CHK_TYPED, DIR_REEL_IN, 2097151},
        '{CMD_POSITION, 0, -1048576, 0, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 0, 0, 1048575, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_TAKEOFF, -1, -1, -1, CHK_SILENT, DIR_PAY_OUT, 0},
        '{CMD_POSITION, -1, -1, -1, CHK_PREDICTED, DIR_PAY_OUT, 0},
        '{CMD_POSITION, 1, -1, 1, CHK_TYPED, DIR_REEL_IN, 2},
        '{CMD_POSITION, 0, 0, -1, CHK_PREDICTED, DIR_PAY_OUT, 0}
    };

    tether_winch_step_planner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .pos_x_mm  (pos_x_mm),
        .pos_y_mm  (pos_y_mm),
        .pos_z_mm  (pos_z_mm),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .direction (direction),
        .length_mm (length_mm),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[tether_winch_step_planner] ERROR");
            $finish;
        end
    end

    // Winch move for one accepted item; returns 1 when the item yields a move.
    function automatic bit plan_winch_move(input logic cmd,
                                           input logic signed [COORD_BITS-1:0] x, y, z,
                                           output winch_move_t move);
        longint dx;
        longint dy;
        longint dz;
        longint unsigned old_sq;
        longint unsigned new_sq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe_bit;
        move = '0;
        if (!is_airborne)
        begin
            if (cmd != CMD_TAKEOFF)
                return 1'b0;
            is_airborne = 1'b1;
            move.dir = DIR_PAY_OUT;
            move.len = LENGTH_W'(slack_mm);
            return 1'b1;
        end
        if (cmd == CMD_TAKEOFF)
            return 1'b0;

        old_sq = longint'(tether_last_x) * tether_last_x + longint'(tether_last_y) * tether_last_y
                 + longint'(tether_last_z) * tether_last_z;
        new_sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
        dx = longint'(x) - longint'(tether_last_x);
        dy = longint'(y) - longint'(tether_last_y);
        dz = longint'(z) - longint'(tether_last_z);
        rem = dx * dx + dy * dy + dz * dz;

        // bit-pair square root, truncated
        root = 0;
        probe_bit = 64'h4000_0000_0000_0000;
        while (probe_bit > rem)
            probe_bit = probe_bit >> 2;
        while (probe_bit != 0)
        begin
            if (rem >= root + probe_bit)
            begin
                rem = rem - (root + probe_bit);
                root = (root >> 1) + probe_bit;
            end
            else
                root = root >> 1;
            probe_bit = probe_bit >> 2;
        end
        if (root > LENGTH_MAX)
            root = LENGTH_MAX;

        move.dir = (new_sq > old_sq) ? DIR_PAY_OUT : DIR_REEL_IN;
        move.len = root[LENGTH_W-1:0];
        tether_last_x = x;
        tether_last_y = y;
        tether_last_z = z;
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return COORD_BITS'(-(1 <<< (COORD_BITS - 1)));
            1: return COORD_BITS'((1 <<< (COORD_BITS - 1)) - 1);
            2: return COORD_BITS'(-1);
            3: return COORD_BITS'(1);
            default: return '0;
        endcase
    endfunction

    // One input transfer, with an optional gap in front; queues what it should yield.
    task automatic transfer_report(input logic cmd,
                                   input logic signed [COORD_BITS-1:0] x, y, z,
                                   input row_check_t chk, input logic typed_dir,
                                   input int typed_len);
        bit taken;
        bit emits;
        winch_move_t predicted;
        if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pos_x_mm <= x;
        pos_y_mm <= y;
        pos_z_mm <= z;
        // in_stall is settled at the falling edge; it decides the next rising edge
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        emits = plan_winch_move(cmd, x, y, z, predicted);
        case (chk)
            CHK_TYPED:     pending_moves.push_back('{typed_dir, LENGTH_W'(typed_len)});
            CHK_PREDICTED: if (emits) pending_moves.push_back(predicted);
            default:       ;
        endcase
    endtask

    // Wait until every queued move has arrived, then let a dropped item finish.
    task automatic drain_planner();
        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_slack(input logic [SLACK_W-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        slack_mm = value;
        @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold so the block backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && moves_checked >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Output checker: sample at the falling edge, count a transfer at the next rising edge.
    initial
    begin
        logic                seen_valid;
        logic                seen_stall;
        logic                seen_dir;
        logic [LENGTH_W-1:0] seen_len;
        winch_move_t         due;
        forever
        begin
            @(negedge clk);
            seen_valid = out_valid;
            seen_stall = out_stall;
            seen_dir   = direction;
            seen_len   = length_mm;
            @(posedge clk);
            if (rst_n && seen_valid === 1'b1 && seen_stall === 1'b0)
            begin
                moves_checked = moves_checked + 1;
                if (pending_moves.size() == 0)
                begin
                    $error("unexpected winch move: direction %0d length_mm %0d",
                           seen_dir, seen_len);
                    error_count = error_count + 1;
                end
                else
                begin
                    due = pending_moves.pop_front();
                    if (seen_dir !== due.dir)
                    begin
                        $error("direction: expected %0d, actual %0d", due.dir, seen_dir);
                        error_count = error_count + 1;
                    end
                    if (seen_len !== due.len)
                    begin
                        $error("length_mm: expected %0d, actual %0d", due.len, seen_len);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        logic                         cmd;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        int pick;
        int reports_sent;
        static int gap_by_phase [PHASES]   = '{25, 0, 50, 25, 0};
        static int stall_by_phase [PHASES] = '{10, 0, 30, 5, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Half the seeds keep the reset slack for takeoff; the rest load extremes first.
        if ($urandom_range(0, 1))
        begin
            load_slack(16'd0);
            load_slack(16'hFFFF);
            case ($urandom_range(0, 2))
                0:       load_slack(16'd0);
                1:       load_slack(16'hFFFF);
                default: load_slack(SLACK_W'($urandom));
            endcase
        end

        sender_gap_pct     = 25;
        receiver_stall_pct = 10;
        foreach (probe_rows[i])
            transfer_report(probe_rows[i].cmd, COORD_BITS'(probe_rows[i].x),
                            COORD_BITS'(probe_rows[i].y), COORD_BITS'(probe_rows[i].z),
                            probe_rows[i].chk, probe_rows[i].dir, probe_rows[i].len);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_planner();
            // slack has no visible effect once airborne, but the port still takes it
            case (phase % 3)
                0:       load_slack(16'hFFFF);
                1:       load_slack(16'd0);
                default: load_slack(SLACK_W'($urandom));
            endcase
            sender_gap_pct     = gap_by_phase[phase];
            receiver_stall_pct = stall_by_phase[phase];
            reports_sent = 0;
            while (reports_sent < REPORTS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                cmd = CMD_POSITION;
                x = tether_last_x;
                y = tether_last_y;
                z = tether_last_z;
                if (pick < 5)
                begin
                    // stray takeoff, dropped by the block
                    cmd = CMD_TAKEOFF;
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                    z = COORD_BITS'($urandom);
                end
                else if (pick < 35)
                begin
                    // short hop around the last position
                    x = COORD_BITS'(tether_last_x + (int'($urandom_range(0, 4000)) - 2000));
                    y = COORD_BITS'(tether_last_y + (int'($urandom_range(0, 4000)) - 2000));
                    z = COORD_BITS'(tether_last_z + (int'($urandom_range(0, 4000)) - 2000));
                end
                else if (pick < 45)
                begin
                    // rotate and mirror the axes: same distance from origin
                    x = $urandom_range(0, 1) ? -tether_last_z : tether_last_z;
                    y = $urandom_range(0, 1) ? -tether_last_x : tether_last_x;
                    z = $urandom_range(0, 1) ? -tether_last_y : tether_last_y;
                end
                else if (pick < 50)
                begin
                    // hover: unchanged position
                end
                else if (pick < 60)
                begin
                    x = extreme_coord();
                    y = extreme_coord();
                    z = extreme_coord();
                end
                else
                begin
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                    z = COORD_BITS'($urandom);
                end
                transfer_report(cmd, x, y, z, CHK_PREDICTED, DIR_PAY_OUT, 0);
                if (cmd == CMD_POSITION)
                    reports_sent = reports_sent + 1;
            end
        end

        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[tether_winch_step_planner] OK");
        else
            $display("[tether_winch_step_planner] ERROR");
        $finish;
    end

endmodule
